@@ design/link_reconnect_backoff_fsm_top_macros.svh @@
// assertion macros shared by the link reconnect controller
// no dependencies; included inside module bodies that assert
`ifndef LINK_RECONNECT_BACKOFF_FSM_TOP_MACROS_SVH
`define LINK_RECONNECT_BACKOFF_FSM_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define LRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lrb_pkg.sv @@
// shared types, codes and constants for the link reconnect controller
// no dependencies; imported by every module of the block
package lrb_pkg;

    // controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE       = 4'b0001,
        ST_CONNECTING = 4'b0010,
        ST_CONNECTED  = 4'b0100,
        ST_WAITING    = 4'b1000
    } t_link_state;

    // state codes as seen on the result port
    localparam logic [1:0] LS_IDLE       = 2'd0;
    localparam logic [1:0] LS_CONNECTING = 2'd1;
    localparam logic [1:0] LS_CONNECTED  = 2'd2;
    localparam logic [1:0] LS_WAITING    = 2'd3;

    // event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_UNCONFIGURED = 3'd1;
    localparam logic [2:0] EV_ATTEMPT      = 3'd2;
    localparam logic [2:0] EV_CONNECTED    = 3'd3;
    localparam logic [2:0] EV_LOST         = 3'd4;
    localparam logic [2:0] EV_BACKOFF      = 3'd5;

    // register indexes on the configuration port
    localparam int          ADDR_W          = 5;
    localparam logic [2:0]  REG_HAVE_PRIM   = 3'd0;
    localparam logic [2:0]  REG_HAVE_FALL   = 3'd1;
    localparam logic [2:0]  REG_TIMEOUT     = 3'd2;
    localparam logic [2:0]  REG_DELAY_0     = 3'd3;
    localparam logic [2:0]  REG_DELAY_1     = 3'd4;
    localparam logic [2:0]  REG_DELAY_2     = 3'd5;
    localparam logic [2:0]  REG_DELAY_3     = 3'd6;

    // register reset values
    localparam logic [31:0] TIMEOUT_RST = 32'd15000;
    localparam logic [31:0] DELAY_0_RST = 32'd5000;
    localparam logic [31:0] DELAY_1_RST = 32'd10000;
    localparam logic [31:0] DELAY_2_RST = 32'd30000;
    localparam logic [31:0] DELAY_3_RST = 32'd60000;

    // failed round counter limits
    localparam logic [7:0] ROUNDS_MAX    = 8'd250;
    localparam logic [7:0] DELAY_IDX_MAX = 8'd3;

    // configuration seen by the core
    typedef struct packed {
        logic             have_primary;
        logic             have_fallback;
        logic [31:0]      timeout_ms;
        logic [3:0][31:0] delay_ms;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [1:0]  link_state;
        logic        connected;
        logic        start_attempt;
        logic        network_index;
        logic [2:0]  event_code;
        logic [31:0] retry_wait_ms;
    } t_result;

    // one-hot state to port code
    function automatic logic [1:0] state_code(input t_link_state st);
        logic [1:0] code;
        case (st)
            ST_CONNECTING: code = LS_CONNECTING;
            ST_CONNECTED:  code = LS_CONNECTED;
            ST_WAITING:    code = LS_WAITING;
            default:       code = LS_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ design/lrb_cfg.sv @@
// configuration registers of the link reconnect controller on an apb-style port
// depends on lrb_pkg
module lrb_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lrb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lrb_pkg::t_cfg              o_cfg
);
    import lrb_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // register writes, out-of-range indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.have_primary  <= 1'b0;
            r_cfg.have_fallback <= 1'b0;
            r_cfg.timeout_ms    <= TIMEOUT_RST;
            r_cfg.delay_ms[0]   <= DELAY_0_RST;
            r_cfg.delay_ms[1]   <= DELAY_1_RST;
            r_cfg.delay_ms[2]   <= DELAY_2_RST;
            r_cfg.delay_ms[3]   <= DELAY_3_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_HAVE_PRIM: r_cfg.have_primary  <= pwdata[0];
                REG_HAVE_FALL: r_cfg.have_fallback <= pwdata[0];
                REG_TIMEOUT:   r_cfg.timeout_ms    <= pwdata;
                REG_DELAY_0:   r_cfg.delay_ms[0]   <= pwdata;
                REG_DELAY_1:   r_cfg.delay_ms[1]   <= pwdata;
                REG_DELAY_2:   r_cfg.delay_ms[2]   <= pwdata;
                REG_DELAY_3:   r_cfg.delay_ms[3]   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // read-back
    always_comb begin
        case (w_idx)
            REG_HAVE_PRIM: prdata = {31'd0, r_cfg.have_primary};
            REG_HAVE_FALL: prdata = {31'd0, r_cfg.have_fallback};
            REG_TIMEOUT:   prdata = r_cfg.timeout_ms;
            REG_DELAY_0:   prdata = r_cfg.delay_ms[0];
            REG_DELAY_1:   prdata = r_cfg.delay_ms[1];
            REG_DELAY_2:   prdata = r_cfg.delay_ms[2];
            REG_DELAY_3:   prdata = r_cfg.delay_ms[3];
            default:       prdata = 32'd0;
        endcase
    end

endmodule

@@ design/lrb_core.sv @@
// reconnect state machine: state registers and next-state / result logic
// depends on lrb_pkg and link_reconnect_backoff_fsm_top_macros.svh
module lrb_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_mode,
    input  logic [31:0]      i_now_ms,
    input  logic             i_link_up,
    input  lrb_pkg::t_cfg    i_cfg,
    output lrb_pkg::t_result o_result
);
    import lrb_pkg::*;
    `include "link_reconnect_backoff_fsm_top_macros.svh"

    t_link_state r_state,     n_state;
    logic        r_net,       n_net;
    logic [7:0]  r_rounds,    n_rounds;
    logic [31:0] r_entry_ms,  n_entry_ms;
    logic [31:0] r_wait_ms,   n_wait_ms;
    logic        r_connected, n_connected;

    logic        w_start;
    logic [2:0]  w_event;
    logic [31:0] w_elapsed;
    logic [1:0]  w_delay_idx;

    // wrapping time since the current state was entered
    assign w_elapsed   = i_now_ms - r_entry_ms;
    assign w_delay_idx = (r_rounds < DELAY_IDX_MAX) ? r_rounds[1:0] : DELAY_IDX_MAX[1:0];

    // next state and event for the item in flight
    always_comb begin
        n_state     = r_state;
        n_net       = r_net;
        n_rounds    = r_rounds;
        n_entry_ms  = r_entry_ms;
        n_wait_ms   = r_wait_ms;
        n_connected = r_connected;
        w_start     = 1'b0;
        w_event     = EV_NONE;
        if (i_mode) begin
            n_connected = 1'b0;
            n_rounds    = 8'd0;
            if (i_cfg.have_primary) begin
                n_state    = ST_CONNECTING;
                n_net      = 1'b0;
                n_entry_ms = i_now_ms;
                w_start    = 1'b1;
                w_event    = EV_ATTEMPT;
            end else begin
                n_state = ST_IDLE;
                w_event = EV_UNCONFIGURED;
            end
        end else begin
            case (r_state)
                ST_CONNECTING: begin
                    if (i_link_up) begin
                        n_state     = ST_CONNECTED;
                        n_connected = 1'b1;
                        n_rounds    = 8'd0;
                        w_event     = EV_CONNECTED;
                    end else if (w_elapsed > i_cfg.timeout_ms) begin
                        if (!r_net && i_cfg.have_fallback) begin
                            // one try on the fallback network
                            n_state    = ST_CONNECTING;
                            n_net      = 1'b1;
                            n_entry_ms = i_now_ms;
                            w_start    = 1'b1;
                            w_event    = EV_ATTEMPT;
                        end else begin
                            // round failed, start the back-off wait
                            n_wait_ms   = i_cfg.delay_ms[w_delay_idx];
                            n_rounds    = (r_rounds < ROUNDS_MAX) ? r_rounds + 8'd1 : r_rounds;
                            n_state     = ST_WAITING;
                            n_entry_ms  = i_now_ms;
                            n_connected = 1'b0;
                            w_event     = EV_BACKOFF;
                        end
                    end
                end
                ST_CONNECTED: begin
                    if (!i_link_up) begin
                        n_connected = 1'b0;
                        n_state     = ST_CONNECTING;
                        n_net       = 1'b0;
                        n_entry_ms  = i_now_ms;
                        w_start     = 1'b1;
                        w_event     = EV_LOST;
                    end
                end
                ST_WAITING: begin
                    if (w_elapsed >= r_wait_ms) begin
                        n_state    = ST_CONNECTING;
                        n_net      = 1'b0;
                        n_entry_ms = i_now_ms;
                        w_start    = 1'b1;
                        w_event    = EV_ATTEMPT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result reflects the state after the step
    always_comb begin
        o_result.link_state    = state_code(n_state);
        o_result.connected     = n_connected;
        o_result.start_attempt = w_start;
        o_result.network_index = n_net;
        o_result.event_code    = w_event;
        o_result.retry_wait_ms = n_wait_ms;
    end

    // state update, one item per cycle while i_step is high
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_net       <= 1'b0;
            r_rounds    <= 8'd0;
            r_entry_ms  <= 32'd0;
            r_wait_ms   <= 32'd0;
            r_connected <= 1'b0;
        end else if (i_step) begin
            r_state     <= n_state;
            r_net       <= n_net;
            r_rounds    <= n_rounds;
            r_entry_ms  <= n_entry_ms;
            r_wait_ms   <= n_wait_ms;
            r_connected <= n_connected;
        end
    end

    // connected flag only ever set in the connected state
    `LRB_ASSERT_IMP(a_conn_state, i_clk, i_rst_n, 1'b1, r_connected == (r_state == ST_CONNECTED), "connected flag out of step with state")
    // failed round counter saturates
    `LRB_ASSERT_IMP(a_rounds_sat, i_clk, i_rst_n, 1'b1, r_rounds <= ROUNDS_MAX, "failed round count above limit")
    // an attempt pulse always leaves the machine connecting
    `LRB_ASSERT_NXT(a_start_conn, i_clk, i_rst_n, i_step && w_start, r_state == ST_CONNECTING, "attempt started but not connecting")

endmodule

@@ design/link_reconnect_backoff_fsm_top.sv @@
// Link reconnect controller with back-off.
// Input channel (i_in_valid/o_in_ready) carries one transfer per poll or
// restart command: i_mode (0 poll, 1 restart), i_now_ms and i_link_up.
// Output channel (o_out_valid/i_out_ready) returns exactly one transfer per
// input: state, connected flag, attempt pulse, network index, event code
// and the current back-off wait.
// Each input goes through the input register, then the state update and the
// result register, which drives the output channel.
// Throughput: one item per cycle while results are taken; the next-state
// logic is a single pass of a wrapping subtract and two 32-bit compares.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that o_in_ready drops until the result
// is taken.
// Synchronous reset puts the machine in idle with counters and waits at zero
// and the registers at their defaults. Configuration goes through the
// apb-style port, register i at byte address 4*i; write it while idle.
// depends on lrb_pkg, lrb_cfg and lrb_core
module link_reconnect_backoff_fsm_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lrb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [31:0]                i_now_ms,
    input  logic                       i_link_up,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_link_state,
    output logic                       o_connected,
    output logic                       o_start_attempt,
    output logic                       o_network_index,
    output logic [2:0]                 o_event_code,
    output logic [31:0]                o_retry_wait_ms
);
    import lrb_pkg::*;

    t_cfg        w_cfg;
    t_result     w_result;
    t_result     r_res;
    logic        r_in_valid;
    logic        r_mode;
    logic [31:0] r_now_ms;
    logic        r_link_up;
    logic        r_out_valid;
    logic        w_out_free;
    logic        w_step;
    logic        w_in_take;

    // handshake control
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;
    assign w_in_take  = i_in_valid && o_in_ready;

    // configuration registers
    lrb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // state machine
    lrb_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_mode    (r_mode),
        .i_now_ms  (r_now_ms),
        .i_link_up (r_link_up),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_mode    <= i_mode;
            r_now_ms  <= i_now_ms;
            r_link_up <= i_link_up;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_res <= w_result;
        end
    end

    // result transfer
    assign o_out_valid     = r_out_valid;
    assign o_link_state    = r_res.link_state;
    assign o_connected     = r_res.connected;
    assign o_start_attempt = r_res.start_attempt;
    assign o_network_index = r_res.network_index;
    assign o_event_code    = r_res.event_code;
    assign o_retry_wait_ms = r_res.retry_wait_ms;

endmodule
